>>> design/tar_pkg.sv
// tar_pkg: shared types and constants for the triangle alpha rasterizer
// holds field widths, request and register codes, the controller state type
// no dependencies
`default_nettype none

package tar_pkg;

  // default store geometry
  localparam int TAR_MAX_WIDTH  = 256;
  localparam int TAR_MAX_HEIGHT = 256;

  // field widths
  localparam int REQ_W     = 2;
  localparam int COORD_W   = 12;
  localparam int COLOR_W   = 8;
  localparam int IDX_W     = 16;
  localparam int COMP_W    = 16;
  localparam int COUNT_W   = 17;
  localparam int SIZE_W    = 9;
  localparam int CFG_IDX_W = 2;

  // datapath widths
  localparam int MUL_W  = 14;
  localparam int EDGE_W = 2 * MUL_W;
  localparam int SUM_W  = 24;
  localparam int WORD_W = 3 * COMP_W;

  // divide by 255 as (s + 1) * floor(2^24 / 255) >> 24, exact for s below 2^24
  localparam logic [16:0] RECIP_255   = 17'd65793;
  localparam int          RECIP_SHIFT = 24;

  // request codes
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_DRAW  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SETUP,
    ST_DRAW,
    ST_DRAIN,
    ST_READ,
    ST_READ_WAIT,
    ST_RESULT
  } tar_state_t;

endpackage

`default_nettype wire

>>> design/triangle_alpha_rasterizer_core.sv
// triangle_alpha_rasterizer_core: rgb frame buffer with clear, blended triangle draw
// and pixel read requests; depends on tar_pkg
// A clear sweeps the whole store (one store write per cycle); a draw runs the
//   edge setup, then walks the bounding box (one pixel per cycle through the frame
//   buffer read-blend-write pipeline) and drains that pipeline; a read waits on the store read.
// Throughput: one transaction at a time; the next is taken once the current one
//   has its result in the output register.
// Reset: control and size registers only; the frame buffer holds no defined
//   contents until the first clear request, and reset does not sweep it.
`default_nettype none

module triangle_alpha_rasterizer_core
  import tar_pkg::*;
#(
  parameter int MAX_WIDTH  = TAR_MAX_WIDTH,
  parameter int MAX_HEIGHT = TAR_MAX_HEIGHT
) (
  input  wire                        clk,
  input  wire                        rst_n,
  // request channel
  input  wire                        in_valid,
  output logic                       in_ready,
  input  wire         [REQ_W-1:0]    in_req_type,
  input  wire  signed [COORD_W-1:0]  in_vertex_a_x,
  input  wire  signed [COORD_W-1:0]  in_vertex_a_y,
  input  wire  signed [COORD_W-1:0]  in_vertex_b_x,
  input  wire  signed [COORD_W-1:0]  in_vertex_b_y,
  input  wire  signed [COORD_W-1:0]  in_vertex_c_x,
  input  wire  signed [COORD_W-1:0]  in_vertex_c_y,
  input  wire         [COLOR_W-1:0]  in_fill_red,
  input  wire         [COLOR_W-1:0]  in_fill_green,
  input  wire         [COLOR_W-1:0]  in_fill_blue,
  input  wire         [COLOR_W-1:0]  in_fill_alpha,
  input  wire         [IDX_W-1:0]    in_read_index,
  // result channel
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic        [COMP_W-1:0]   out_pixel_red,
  output logic        [COMP_W-1:0]   out_pixel_green,
  output logic        [COMP_W-1:0]   out_pixel_blue,
  output logic        [COUNT_W-1:0]  out_covered_count,
  // configuration channel
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire         [CFG_IDX_W-1:0] cfg_index,
  input  wire         [SIZE_W-1:0]   cfg_wdata
);

  localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W     = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
  localparam int DIM_W      = SIZE_W + 4;

  // configuration registers
  logic [SIZE_W-1:0] img_width_r;
  logic [SIZE_W-1:0] img_height_r;
  logic [SIZE_W-1:0] w_eff;
  logic [SIZE_W-1:0] h_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r  <= SIZE_W'(256);
      img_height_r <= SIZE_W'(256);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_IMG_WIDTH:  img_width_r  <= cfg_wdata;
        CFG_IMG_HEIGHT: img_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // size in use: zero acts as one, above the store limit acts as the limit
  always_comb begin
    if (img_width_r == '0) begin
      w_eff = SIZE_W'(1);
    end else if (DIM_W'(img_width_r) > DIM_W'(MAX_WIDTH)) begin
      w_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      w_eff = img_width_r;
    end
    if (img_height_r == '0) begin
      h_eff = SIZE_W'(1);
    end else if (DIM_W'(img_height_r) > DIM_W'(MAX_HEIGHT)) begin
      h_eff = SIZE_W'(MAX_HEIGHT);
    end else begin
      h_eff = img_height_r;
    end
  end

  // controller and datapath registers
  tar_state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] vx_r [3];
  logic signed [COORD_W-1:0] vy_r [3];
  logic        [COLOR_W-1:0] alpha_r;
  logic        [SUM_W-1:0]   kc_r [3];
  logic        [SIZE_W-1:0]  x0_r, y0_r, x1_r, y1_r, x_r, y_r;
  logic        [2:0]         step_r;
  logic signed [EDGE_W-1:0]  prod_r;
  logic signed [EDGE_W-1:0]  edge_row_r [3];
  logic signed [EDGE_W-1:0]  edge_cur_r [3];
  logic        [ADDR_W-1:0]  addr_row_r, addr_r;
  logic        [ADDR_W-1:0]  clr_addr_r;
  logic        [ADDR_W-1:0]  rd_idx_r;
  logic                      rd_ok_r;
  logic        [COUNT_W-1:0] count_r;
  logic        [WORD_W-1:0]  res_pix_r;

  // blend pipeline
  logic                      v1_r, v2_r, v3_r;
  logic        [ADDR_W-1:0]  addr1_r, addr2_r, addr3_r;
  logic        [SUM_W-1:0]   s_r [3];
  logic        [COMP_W-1:0]  q_r [3];

  // output register
  logic                      out_valid_r;
  logic        [WORD_W-1:0]  out_pix_r;
  logic        [COUNT_W-1:0] out_cnt_r;

  // frame buffer
  logic        [WORD_W-1:0]  fb_mem [STORE_SIZE];
  logic        [WORD_W-1:0]  rd_q;
  logic        [ADDR_W-1:0]  rd_addr;
  logic                      wr_en;
  logic        [ADDR_W-1:0]  wr_addr;
  logic        [WORD_W-1:0]  wr_data;

  logic in_fire;
  logic res_load;
  logic pix_inside;
  logic pix_issue;
  logic walk_last;
  logic clr_last;
  logic pipe_busy;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign res_load  = (state_r == ST_RESULT) && (!out_valid_r || out_ready);
  assign pipe_busy = v1_r || v2_r || v3_r;
  assign walk_last = (x_r == x1_r) && (y_r == y1_r);
  assign clr_last  = (clr_addr_r == ADDR_W'(STORE_SIZE - 1));

  // bounding box of the incoming triangle, clipped to the image
  logic signed [DIM_W-1:0] bx_min, bx_max, by_min, by_max;
  logic signed [DIM_W-1:0] bx0, bx1, by0, by1;
  logic signed [DIM_W-1:0] w_m1, h_m1;
  logic                    box_empty;

  always_comb begin
    bx_min = DIM_W'(in_vertex_a_x);
    if (DIM_W'(in_vertex_b_x) < bx_min) bx_min = DIM_W'(in_vertex_b_x);
    if (DIM_W'(in_vertex_c_x) < bx_min) bx_min = DIM_W'(in_vertex_c_x);
    bx_max = DIM_W'(in_vertex_a_x);
    if (DIM_W'(in_vertex_b_x) > bx_max) bx_max = DIM_W'(in_vertex_b_x);
    if (DIM_W'(in_vertex_c_x) > bx_max) bx_max = DIM_W'(in_vertex_c_x);
    by_min = DIM_W'(in_vertex_a_y);
    if (DIM_W'(in_vertex_b_y) < by_min) by_min = DIM_W'(in_vertex_b_y);
    if (DIM_W'(in_vertex_c_y) < by_min) by_min = DIM_W'(in_vertex_c_y);
    by_max = DIM_W'(in_vertex_a_y);
    if (DIM_W'(in_vertex_b_y) > by_max) by_max = DIM_W'(in_vertex_b_y);
    if (DIM_W'(in_vertex_c_y) > by_max) by_max = DIM_W'(in_vertex_c_y);
    w_m1 = $signed({4'b0, w_eff}) - DIM_W'(1);
    h_m1 = $signed({4'b0, h_eff}) - DIM_W'(1);
    bx0  = (bx_min < 0) ? '0 : bx_min;
    by0  = (by_min < 0) ? '0 : by_min;
    bx1  = (bx_max > w_m1) ? w_m1 : bx_max;
    by1  = (by_max > h_m1) ? h_m1 : by_max;
    box_empty = (bx0 > bx1) || (by0 > by1);
  end

  // per-edge step values: p1 is vertex i, p2 the next vertex around
  logic signed [COORD_W:0] dex [3];
  logic signed [COORD_W:0] dey [3];

  always_comb begin
    int j;
    for (int i = 0; i < 3; i++) begin
      j = (i == 2) ? 0 : i + 1;
      dex[i] = (COORD_W + 1)'(vy_r[i]) - (COORD_W + 1)'(vy_r[j]);
      dey[i] = (COORD_W + 1)'(vx_r[j]) - (COORD_W + 1)'(vx_r[i]);
    end
  end

  // shared setup multiplier: the edge terms in turn, then the row base address
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [MUL_W-1:0] x0s, y0s, ws;
  logic signed [MUL_W-1:0] vxs [3];
  logic signed [MUL_W-1:0] vys [3];

  always_comb begin
    x0s = $signed({5'b0, x0_r});
    y0s = $signed({5'b0, y0_r});
    ws  = $signed({5'b0, w_eff});
    for (int i = 0; i < 3; i++) begin
      vxs[i] = MUL_W'(vx_r[i]);
      vys[i] = MUL_W'(vy_r[i]);
    end
    case (step_r)
      3'd0: begin mul_a = x0s - vxs[1];    mul_b = vys[0] - vys[1]; end
      3'd1: begin mul_a = vxs[0] - vxs[1]; mul_b = y0s - vys[1];    end
      3'd2: begin mul_a = x0s - vxs[2];    mul_b = vys[1] - vys[2]; end
      3'd3: begin mul_a = vxs[1] - vxs[2]; mul_b = y0s - vys[2];    end
      3'd4: begin mul_a = x0s - vxs[0];    mul_b = vys[2] - vys[0]; end
      3'd5: begin mul_a = vxs[2] - vxs[0]; mul_b = y0s - vys[0];    end
      3'd6: begin mul_a = y0s;             mul_b = ws;              end
      default: begin mul_a = '0;           mul_b = '0;              end
    endcase
  end

  // inside when the signs of all edge values agree
  assign pix_inside = (edge_cur_r[0][EDGE_W-1] == edge_cur_r[1][EDGE_W-1]) &&
                      (edge_cur_r[1][EDGE_W-1] == edge_cur_r[2][EDGE_W-1]);

  // next state and memory port control
  always_comb begin
    state_nxt = state_r;
    pix_issue = 1'b0;
    rd_addr   = rd_idx_r;
    wr_en     = v3_r;
    wr_addr   = addr3_r;
    wr_data   = {q_r[0], q_r[1], q_r[2]};
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_req_type)
            REQ_CLEAR: state_nxt = ST_CLEAR;
            REQ_DRAW:  state_nxt = box_empty ? ST_RESULT : ST_SETUP;
            REQ_READ:  state_nxt = ST_READ;
            default:   state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
        wr_data = '0;
        if (clr_last) state_nxt = ST_RESULT;
      end
      ST_SETUP: begin
        if (step_r == 3'd7) state_nxt = ST_DRAW;
      end
      ST_DRAW: begin
        rd_addr   = addr_r;
        pix_issue = pix_inside;
        if (walk_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!pipe_busy) state_nxt = ST_RESULT;
      end
      ST_READ:      state_nxt = ST_READ_WAIT;
      ST_READ_WAIT: state_nxt = ST_RESULT;
      ST_RESULT: begin
        if (res_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request capture, setup, box walk and clear sweep
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          vx_r[0]    <= in_vertex_a_x;
          vy_r[0]    <= in_vertex_a_y;
          vx_r[1]    <= in_vertex_b_x;
          vy_r[1]    <= in_vertex_b_y;
          vx_r[2]    <= in_vertex_c_x;
          vy_r[2]    <= in_vertex_c_y;
          alpha_r    <= in_fill_alpha;
          kc_r[0]    <= {(2 * COLOR_W)'(in_fill_alpha) * (2 * COLOR_W)'(in_fill_red), 8'd127};
          kc_r[1]    <= {(2 * COLOR_W)'(in_fill_alpha) * (2 * COLOR_W)'(in_fill_green), 8'd127};
          kc_r[2]    <= {(2 * COLOR_W)'(in_fill_alpha) * (2 * COLOR_W)'(in_fill_blue), 8'd127};
          x0_r       <= SIZE_W'(bx0);
          y0_r       <= SIZE_W'(by0);
          x1_r       <= SIZE_W'(bx1);
          y1_r       <= SIZE_W'(by1);
          x_r        <= SIZE_W'(bx0);
          y_r        <= SIZE_W'(by0);
          step_r     <= '0;
          clr_addr_r <= '0;
          rd_idx_r   <= ADDR_W'(in_read_index);
          rd_ok_r    <= (32'(in_read_index) < STORE_SIZE);
          count_r    <= '0;
          res_pix_r  <= '0;
        end
      end
      ST_CLEAR: begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      ST_SETUP: begin
        step_r <= step_r + 3'd1;
        // accumulate the product of the previous step
        case (step_r)
          3'd1: edge_row_r[0] <= prod_r;
          3'd2: edge_row_r[0] <= edge_row_r[0] - prod_r;
          3'd3: edge_row_r[1] <= prod_r;
          3'd4: edge_row_r[1] <= edge_row_r[1] - prod_r;
          3'd5: edge_row_r[2] <= prod_r;
          3'd6: edge_row_r[2] <= edge_row_r[2] - prod_r;
          3'd7: begin
            addr_row_r <= ADDR_W'(prod_r) + ADDR_W'(x0_r);
            addr_r     <= ADDR_W'(prod_r) + ADDR_W'(x0_r);
            for (int i = 0; i < 3; i++) begin
              edge_cur_r[i] <= edge_row_r[i];
            end
          end
          default: ;
        endcase
      end
      ST_DRAW: begin
        if (pix_issue) count_r <= count_r + COUNT_W'(1);
        if (x_r == x1_r) begin
          if (y_r != y1_r) begin
            // next row: edges step in y, address steps by one row
            y_r        <= y_r + SIZE_W'(1);
            x_r        <= x0_r;
            addr_row_r <= addr_row_r + ADDR_W'(w_eff);
            addr_r     <= addr_row_r + ADDR_W'(w_eff);
            for (int i = 0; i < 3; i++) begin
              edge_row_r[i] <= edge_row_r[i] + EDGE_W'(dey[i]);
              edge_cur_r[i] <= edge_row_r[i] + EDGE_W'(dey[i]);
            end
          end
        end else begin
          x_r    <= x_r + SIZE_W'(1);
          addr_r <= addr_r + ADDR_W'(1);
          for (int i = 0; i < 3; i++) begin
            edge_cur_r[i] <= edge_cur_r[i] + EDGE_W'(dex[i]);
          end
        end
      end
      ST_READ_WAIT: begin
        res_pix_r <= rd_ok_r ? rd_q : '0;
      end
      default: ;
    endcase
  end

  // blend pipeline: read, weighted sum, divide by 255, write back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= pix_issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    logic [SUM_W:0]           s_inc;
    logic [SUM_W+17:0]        q_full;
    addr1_r <= addr_r;
    addr2_r <= addr1_r;
    addr3_r <= addr2_r;
    for (int k = 0; k < 3; k++) begin
      s_r[k]  <= SUM_W'((8'd255 - alpha_r) * rd_q[WORD_W-1-COMP_W*k -: COMP_W]) + kc_r[k];
      s_inc   = (SUM_W + 1)'(s_r[k]) + (SUM_W + 1)'(1);
      q_full  = s_inc * RECIP_255;
      q_r[k]  <= q_full[RECIP_SHIFT +: COMP_W];
    end
  end

  // frame buffer memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) fb_mem[wr_addr] <= wr_data;
    rd_q <= fb_mem[rd_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_pix_r <= res_pix_r;
      out_cnt_r <= count_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_red     = out_pix_r[WORD_W-1 -: COMP_W];
  assign out_pixel_green   = out_pix_r[WORD_W-1-COMP_W -: COMP_W];
  assign out_pixel_blue    = out_pix_r[COMP_W-1:0];
  assign out_covered_count = out_cnt_r;

  // write-back only happens while a draw owns the buffer
  a_wb_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r |-> (state_r == ST_DRAW || state_r == ST_DRAIN))
    else $error("blend write-back outside a draw");

  // a result is only presented once the blend pipeline is empty
  a_result_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESULT) |-> !pipe_busy)
    else $error("result loaded with blend pipeline busy");

  // pixel data and coverage never appear in the same result
  a_fields_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_pix_r != '0)) |-> (out_cnt_r == '0))
    else $error("result carries both pixel data and coverage");

  // output valid rises only from the result state
  a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_RESULT))
    else $error("output valid raised outside result state");

endmodule

`default_nettype wire
